// File: rtl/ufcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcs_pkg
// Shared constants, codes, types and clamp helpers of the union-find
// cluster spacing engine.
// ----------------------------------------------------------------------------
package ufcs_pkg;

  localparam int MAX_NODES    = 1024;
  localparam int NODE_W       = $clog2(MAX_NODES);
  localparam int MAX_CLUSTERS = 16;
  localparam int RING_W       = $clog2(MAX_CLUSTERS);
  localparam int SEEN_W       = $clog2(MAX_CLUSTERS + 1);

  // fixed field widths
  localparam int NC_W      = 11;
  localparam int KC_W      = 5;
  localparam int NODE_ID_W = 16;
  localparam int WEIGHT_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(MAX_NODES - 1);

  typedef enum logic [1:0] {
    ST_MERGED  = 2'd0,
    ST_SAME    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'd1;

  typedef struct packed {
    logic              start_clear;
    logic              start_edge;
    logic [NODE_W-1:0] to_node;
    logic [NODE_W-1:0] from_node;
  } walk_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic same;
  } walk_sts_t;

  typedef struct packed {
    logic                       clear;
    logic                       push;
    logic signed [WEIGHT_W-1:0] weight;
  } ring_cmd_t;

  function automatic logic [NC_W-1:0] clamp_nodes(input logic [NC_W-1:0] n);
    logic [NC_W-1:0] r;
    r = n;
    if (n == '0) r = NC_W'(1);
    else if (n > NC_W'(MAX_NODES)) r = NC_W'(MAX_NODES);
    return r;
  endfunction

  function automatic logic [KC_W-1:0] clamp_k(input logic [KC_W-1:0] k);
    logic [KC_W-1:0] r;
    r = k;
    if (k < KC_W'(2)) r = KC_W'(2);
    else if (k > KC_W'(MAX_CLUSTERS)) r = KC_W'(MAX_CLUSTERS);
    return r;
  endfunction

endpackage

// File: rtl/ufcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcs_if
// Valid/ready channels of the engine: edge words in, result words out.
// ----------------------------------------------------------------------------
interface ufcs_in_if;
  import ufcs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [NODE_ID_W-1:0]       to_node;
  logic [NODE_ID_W-1:0]       from_node;
  logic signed [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, operation, to_node, from_node, edge_weight, input ready);
  modport sink   (input valid, operation, to_node, from_node, edge_weight, output ready);
endinterface

interface ufcs_out_if;
  import ufcs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic signed [WEIGHT_W-1:0] spacing;
  logic                       spacing_valid;
  logic [NC_W-1:0]            clusters_left;

  modport source (output valid, status, spacing, spacing_valid, clusters_left, input ready);
  modport sink   (input valid, status, spacing, spacing_valid, clusters_left, output ready);
endinterface

// File: rtl/ufcs_parent_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcs_parent_mem
// Single-port parent table, registered read data, read-first.
// ----------------------------------------------------------------------------
module ufcs_parent_mem (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ufcs_pkg::NODE_W-1:0] addr,
  input  logic [ufcs_pkg::NODE_W-1:0] wdata,
  output logic [ufcs_pkg::NODE_W-1:0] rdata
);
  import ufcs_pkg::*;

  logic [NODE_W-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/ufcs_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcs_walker
// Parent table sequencer: identity sweep, two root walks with path halving,
// and the final link of the from-root under the to-root.
// ----------------------------------------------------------------------------
module ufcs_walker (
  input  logic                  clk,
  input  logic                  rst,
  input  ufcs_pkg::walk_cmd_t   cmd,
  output ufcs_pkg::walk_sts_t   sts
);
  import ufcs_pkg::*;

  typedef enum logic [6:0] {
    W_IDLE  = 7'b0000001,
    W_SWEEP = 7'b0000010,
    W_RD0   = 7'b0000100,
    W_PAR   = 7'b0001000,
    W_GP    = 7'b0010000,
    W_RD    = 7'b0100000,
    W_LINK  = 7'b1000000
  } walk_state_t;

  walk_state_t       state, state_next;
  logic [NODE_W-1:0] sweep_idx;
  logic              second;
  logic [NODE_W-1:0] cur, par, node_b, root_a;

  logic              mem_we;
  logic [NODE_W-1:0] mem_addr, mem_wdata, mem_rdata;

  ufcs_parent_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = cur;
    mem_wdata  = mem_rdata;
    sts        = '0;
    sts.busy   = (state != W_IDLE);
    unique case (state)
      W_IDLE: begin
        if (cmd.start_clear) state_next = W_SWEEP;
        else if (cmd.start_edge) state_next = W_RD0;
      end
      W_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_idx;
        mem_wdata = sweep_idx;
        if (sweep_idx == NODE_LAST) begin
          sts.done   = 1'b1;
          state_next = W_IDLE;
        end
      end
      W_RD0: begin
        mem_addr   = cur;
        state_next = W_PAR;
      end
      W_PAR: begin
        mem_addr   = mem_rdata;
        state_next = W_GP;
      end
      W_GP: begin
        if (mem_rdata == par) begin
          if (!second) begin
            state_next = W_RD0;
          end else if (par == root_a) begin
            sts.done   = 1'b1;
            sts.same   = 1'b1;
            state_next = W_IDLE;
          end else begin
            state_next = W_LINK;
          end
        end else begin
          // halve: point cur at its grandparent
          mem_we     = 1'b1;
          mem_addr   = cur;
          mem_wdata  = mem_rdata;
          state_next = W_RD;
        end
      end
      W_RD: begin
        mem_addr   = par;
        state_next = W_GP;
      end
      W_LINK: begin
        mem_we     = 1'b1;
        mem_addr   = par;
        mem_wdata  = root_a;
        sts.done   = 1'b1;
        state_next = W_IDLE;
      end
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= W_SWEEP;
      sweep_idx <= '0;
      second    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == W_IDLE && cmd.start_clear) sweep_idx <= '0;
      else if (state == W_SWEEP) sweep_idx <= sweep_idx + 1'b1;
      if (state == W_IDLE && cmd.start_edge) second <= 1'b0;
      else if (state == W_GP && mem_rdata == par) second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == W_IDLE && cmd.start_edge) begin
      cur    <= cmd.to_node;
      node_b <= cmd.from_node;
    end else if (state == W_PAR) begin
      par <= mem_rdata;
    end else if (state == W_GP) begin
      if (mem_rdata == par) begin
        if (!second) begin
          root_a <= par;
          cur    <= node_b;
        end
      end else begin
        cur <= par;
        par <= mem_rdata;
      end
    end
  end

endmodule

// File: rtl/ufcs_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcs_ring
// Ring of recent merge weights and the spacing lookup k-1 merges back.
// ----------------------------------------------------------------------------
module ufcs_ring (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ufcs_pkg::ring_cmd_t                     cmd,
  input  logic [ufcs_pkg::KC_W-1:0]               k_eff,
  output logic signed [ufcs_pkg::WEIGHT_W-1:0]    spacing,
  output logic                                    spacing_valid
);
  import ufcs_pkg::*;

  logic signed [WEIGHT_W-1:0] ring [MAX_CLUSTERS];
  logic [RING_W-1:0]          wp;
  logic [SEEN_W-1:0]          seen;
  logic [KC_W-1:0]            back;
  logic [RING_W-1:0]          rd_idx;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wp   <= '0;
      seen <= '0;
    end else if (cmd.push) begin
      wp <= wp + 1'b1;
      if (seen < SEEN_W'(MAX_CLUSTERS)) seen <= seen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring[wp] <= cmd.weight;
    end
  end

  assign back          = k_eff - 1'b1;
  assign rd_idx        = wp - back[RING_W-1:0];
  assign spacing_valid = (seen >= SEEN_W'(back));
  assign spacing       = spacing_valid ? ring[rd_idx] : '0;

endmodule

// File: rtl/union_find_cluster_spacing_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_cluster_spacing_top
// Kruskal single-link clustering engine over a 1024-entry parent table.
// ----------------------------------------------------------------------------
// Edges go in sorted by weight; one result word comes out per input word.
// The parent table is one single-port memory, so the reads and writes of a
// walk go one after another; each extra level a walk climbs adds a halving
// write and a read. An edge with a node out of range skips the walk. A clear
// rewrites all 1024 table entries. After reset the same sweep runs and no
// edge is taken until it ends; configuration writes are taken at any time.
// The next edge may be taken while a result still waits in the output
// register.
module union_find_cluster_spacing_top (
  input  logic                          clk,
  input  logic                          rst,
  ufcs_in_if.sink                       in_ch,
  ufcs_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ufcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ufcs_pkg::NC_W-1:0]     cfg_data
);
  import ufcs_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_WALK = 4'b0010,
    T_FIN  = 4'b0100,
    T_OUT  = 4'b1000
  } top_state_t;

  top_state_t                 state;
  logic [NC_W-1:0]            node_count;
  logic [KC_W-1:0]            cluster_count;
  logic [NC_W-1:0]            comp_count;
  status_t                    status_q;
  logic signed [WEIGHT_W-1:0] weight_q;

  logic [NC_W-1:0] n_eff;
  logic            accept;
  logic            in_range;
  walk_cmd_t       wcmd;
  walk_sts_t       wsts;
  ring_cmd_t       rcmd;
  logic signed [WEIGHT_W-1:0] ring_spacing;
  logic            ring_valid;
  logic            out_load;

  assign n_eff    = clamp_nodes(node_count);
  assign in_ch.ready = (state == T_IDLE) && !wsts.busy;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_range = (in_ch.to_node < NODE_ID_W'(n_eff)) &&
                    (in_ch.from_node < NODE_ID_W'(n_eff));
  assign out_load = (state == T_OUT) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    wcmd             = '0;
    wcmd.to_node     = in_ch.to_node[NODE_W-1:0];
    wcmd.from_node   = in_ch.from_node[NODE_W-1:0];
    wcmd.start_clear = accept && (in_ch.operation == OP_CLEAR);
    wcmd.start_edge  = accept && (in_ch.operation == OP_EDGE) && in_range;
    rcmd.clear       = wcmd.start_clear;
    rcmd.push        = (state == T_FIN) && (status_q == ST_MERGED);
    rcmd.weight      = weight_q;
  end

  ufcs_walker u_walker (
    .clk (clk),
    .rst (rst),
    .cmd (wcmd),
    .sts (wsts)
  );

  ufcs_ring u_ring (
    .clk           (clk),
    .rst           (rst),
    .cmd           (rcmd),
    .k_eff         (clamp_k(cluster_count)),
    .spacing       (ring_spacing),
    .spacing_valid (ring_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= NC_W'(MAX_NODES);
      cluster_count <= KC_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_COUNT:    node_count    <= cfg_data;
        CFG_CLUSTER_COUNT: cluster_count <= cfg_data[KC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      comp_count   <= NC_W'(MAX_NODES);
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            if (in_ch.operation == OP_CLEAR) begin
              comp_count <= n_eff;
              state      <= T_WALK;
            end else if (in_range) begin
              state <= T_WALK;
            end else begin
              state <= T_OUT;
            end
          end
        end
        T_WALK: if (wsts.done) state <= T_FIN;
        T_FIN: begin
          if (status_q == ST_MERGED && comp_count != '0) comp_count <= comp_count - 1'b1;
          state <= T_OUT;
        end
        T_OUT: if (out_load) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      weight_q <= in_ch.edge_weight;
      if (in_ch.operation == OP_CLEAR) status_q <= ST_CLEARED;
      else if (!in_range) status_q <= ST_RANGE;
      else status_q <= ST_MERGED;
    end else if (state == T_WALK && wsts.done && status_q != ST_CLEARED) begin
      status_q <= wsts.same ? ST_SAME : ST_MERGED;
    end
    if (out_load) begin
      out_ch.status        <= status_q;
      out_ch.spacing       <= ring_spacing;
      out_ch.spacing_valid <= ring_valid;
      out_ch.clusters_left <= comp_count;
    end
  end

endmodule

// File: rtl/ufcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcs_port_props
// Port-level checks of the cluster spacing engine, bound to the top level.
// ----------------------------------------------------------------------------
module ufcs_port_props (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [1:0]                           status,
  input logic signed [ufcs_pkg::WEIGHT_W-1:0] spacing,
  input logic                                 spacing_valid,
  input logic [ufcs_pkg::NC_W-1:0]            clusters_left
);
  import ufcs_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_CLEARED) |-> !spacing_valid && (clusters_left != '0))
    else $error("clear result carries a spacing or no clusters");

  a_spacing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !spacing_valid |-> (spacing == '0))
    else $error("spacing nonzero while not valid");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(spacing)
                                && $stable(clusters_left))
    else $error("stalled result changed");

endmodule

bind union_find_cluster_spacing_top ufcs_port_props u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .spacing       (out_ch.spacing),
  .spacing_valid (out_ch.spacing_valid),
  .clusters_left (out_ch.clusters_left)
);

// File: bench/ufcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcs_checker
// Watches the edge, result and config ports of the clustering engine. Keeps
// its own parent table, merge-weight ring and counters, works out the result
// word for every accepted edge word and compares each result word, field by
// field, with the oldest expected one.
// ----------------------------------------------------------------------------
module ufcs_checker (
  input  logic                           clk,
  input  logic                           rst,
  ufcs_in_if                             edge_ch,
  ufcs_out_if                            result_ch,
  input  logic                           cfg_we,
  input  logic [ufcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ufcs_pkg::NC_W-1:0]      cfg_data,
  output int                             check_failures,
  output int                             words_pending
);
  import ufcs_pkg::*;

  typedef struct packed {
    status_t                    status;
    logic signed [WEIGHT_W-1:0] spacing;
    logic                       spacing_valid;
    logic [NC_W-1:0]            clusters_left;
  } cluster_word_t;

  logic [NODE_W-1:0]          parent_of [MAX_NODES];
  logic signed [WEIGHT_W-1:0] merge_weights [MAX_CLUSTERS];
  logic [RING_W-1:0]          ring_wr;
  logic [SEEN_W-1:0]          merges_done;
  logic [NC_W-1:0]            components;
  logic [NC_W-1:0]            node_count_reg;
  logic [KC_W-1:0]            k_reg;

  cluster_word_t expected_words [$];

  initial begin
    check_failures = 0;
    words_pending  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (check_failures < 50) $display("%0t ufcs_checker: %s", $time, msg);
    check_failures++;
  endtask

  function automatic int live_nodes();
    int n;
    n = int'(node_count_reg);
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic int target_k();
    int k;
    k = int'(k_reg);
    if (k < 2) k = 2;
    if (k > MAX_CLUSTERS) k = MAX_CLUSTERS;
    return k;
  endfunction

  // walk to the root, halving the path on the way
  function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] par;
    int hops;
    cur  = node;
    par  = parent_of[cur];
    hops = 0;
    while (parent_of[par] != par && hops < MAX_NODES) begin
      parent_of[cur] = parent_of[par];
      cur = par;
      par = parent_of[par];
      hops++;
    end
    return par;
  endfunction

  task automatic clear_clusters();
    for (int i = 0; i < MAX_NODES; i++) parent_of[i] = NODE_W'(i);
    for (int i = 0; i < MAX_CLUSTERS; i++) merge_weights[i] = '0;
    ring_wr     = '0;
    merges_done = '0;
    components  = NC_W'(live_nodes());
  endtask

  task automatic kruskal_step(input logic op, input logic [NODE_ID_W-1:0] to,
                              input logic [NODE_ID_W-1:0] from,
                              input logic signed [WEIGHT_W-1:0] w,
                              output cluster_word_t r);
    logic [NODE_W-1:0] root_to;
    logic [NODE_W-1:0] root_from;
    int back;
    r = '0;
    if (op == OP_CLEAR) begin
      clear_clusters();
      r.status = ST_CLEARED;
    end else if (int'(to) >= live_nodes() || int'(from) >= live_nodes()) begin
      r.status = ST_RANGE;
    end else begin
      root_to   = root_of(to[NODE_W-1:0]);
      root_from = root_of(from[NODE_W-1:0]);
      if (root_to == root_from) begin
        r.status = ST_SAME;
      end else begin
        parent_of[root_from]   = root_to;
        merge_weights[ring_wr] = w;
        ring_wr++;
        if (merges_done < MAX_CLUSTERS) merges_done++;
        if (components != '0) components--;
        r.status = ST_MERGED;
      end
    end
    if (r.status != ST_CLEARED) begin
      back = target_k() - 1;
      if (int'(merges_done) >= back) begin
        r.spacing       = merge_weights[RING_W'(int'(ring_wr) - back)];
        r.spacing_valid = 1'b1;
      end
    end
    r.clusters_left = components;
  endtask

  always @(posedge clk) begin : watch
    cluster_word_t want;
    if (rst) begin
      node_count_reg = NC_W'(MAX_NODES);
      k_reg          = KC_W'(4);
      clear_clusters();
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT:    node_count_reg = cfg_data;
          CFG_CLUSTER_COUNT: k_reg = cfg_data[KC_W-1:0];
          default: ;
        endcase
      end
      if (result_ch.valid && result_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word with no edge word pending, status %0d",
                                    result_ch.status));
        end else begin
          want = expected_words.pop_front();
          if (result_ch.status != want.status)
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, result_ch.status));
          if (result_ch.spacing != want.spacing)
            report_mismatch($sformatf("spacing expected %0d got %0d",
                                      want.spacing, result_ch.spacing));
          if (result_ch.spacing_valid != want.spacing_valid)
            report_mismatch($sformatf("spacing_valid expected %0d got %0d",
                                      want.spacing_valid, result_ch.spacing_valid));
          if (result_ch.clusters_left != want.clusters_left)
            report_mismatch($sformatf("clusters_left expected %0d got %0d",
                                      want.clusters_left, result_ch.clusters_left));
        end
      end
      if (edge_ch.valid && edge_ch.ready) begin
        kruskal_step(edge_ch.operation, edge_ch.to_node, edge_ch.from_node,
                     edge_ch.edge_weight, want);
        expected_words = {expected_words, want};
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// File: bench/tb_union_find_cluster_spacing_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_union_find_cluster_spacing_top
// Drives the clustering engine with directed edges (extremes, range errors,
// a deep chain, clears, component count at zero) and then random phases of
// sorted edges under several node and cluster counts, with random gaps on
// both channels and one long output stall. ufcs_checker does the checking.
// ----------------------------------------------------------------------------
module tb_union_find_cluster_spacing_top;
  import ufcs_pkg::*;

  localparam longint RUN_LIMIT_NS    = 4_000_000;
  localparam int     NUM_PHASES      = 12;
  localparam int     PHASE_WORDS     = 160;
  localparam int     KEEP_PHASE      = 7;
  localparam int     PRESSURE_AT     = 1500;
  localparam int     PRESSURE_CYCLES = 400;
  localparam longint WEIGHT_MAX      = 64'sd2147483647;
  localparam longint WEIGHT_MIN      = -64'sd2147483648;

  localparam int PHASE_NODES [NUM_PHASES] = '{2047, 8, 16, 64, 0, 5, 300, 1024, 32, 1025, 12, 2};
  localparam int PHASE_K     [NUM_PHASES] = '{16, 31, 2, 3, 0, 17, 5, 1, 16, 9, 4, 7};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NC_W-1:0]      cfg_data;
  int                   check_failures;
  int                   words_pending;
  int                   words_sent;
  int                   src_idle_pct;
  int                   snk_idle_pct;
  bit                   stall_done;

  ufcs_in_if  edge_ch ();
  ufcs_out_if result_ch ();

  union_find_cluster_spacing_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (edge_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ufcs_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .edge_ch        (edge_ch),
    .result_ch      (result_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .check_failures (check_failures),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_union_find_cluster_spacing_top: FAIL");
    $finish;
  end

  // result side: random back-pressure, one long hold-off
  initial begin
    result_ch.ready = 1'b0;
    stall_done      = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && words_sent >= PRESSURE_AT) begin
        stall_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_word(input logic op, input int to, input int from, input longint w);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      edge_ch.valid <= 1'b0;
      @(negedge clk);
    end
    edge_ch.valid       <= 1'b1;
    edge_ch.operation   <= op;
    edge_ch.to_node     <= NODE_ID_W'(to);
    edge_ch.from_node   <= NODE_ID_W'(from);
    edge_ch.edge_weight <= WEIGHT_W'(w);
    do @(posedge clk); while (!edge_ch.ready);
    words_sent++;
    if (words_sent < 650) begin
      src_idle_pct = 11;
      snk_idle_pct = 56;
    end else if (words_sent < 1300) begin
      src_idle_pct = 56;
      snk_idle_pct = 11;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    edge_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // upper data bits ride along on the k write and must be ignored
  task automatic set_config(input int nodes, input int k);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NODE_COUNT;
    cfg_data  <= NC_W'(nodes);
    @(negedge clk);
    cfg_index <= CFG_CLUSTER_COUNT;
    cfg_data  <= NC_W'(($urandom_range(63) << KC_W) | k);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int     n_eff;
    int     window;
    int     roll;
    int     a;
    int     b;
    int     chain_tip;
    longint w;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_NODE_COUNT;
    cfg_data            = '0;
    edge_ch.valid       = 1'b0;
    edge_ch.operation   = OP_EDGE;
    edge_ch.to_node     = '0;
    edge_ch.from_node   = '0;
    edge_ch.edge_weight = '0;
    words_sent          = 0;
    src_idle_pct        = 11;
    snk_idle_pct        = 56;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, range errors, deep chain, clear
    send_word(OP_EDGE, 0, 1023, WEIGHT_MIN);
    send_word(OP_EDGE, 1023, 0, WEIGHT_MIN);
    send_word(OP_EDGE, 1024, 0, WEIGHT_MIN);
    send_word(OP_EDGE, 3, 65535, -1000);
    send_word(OP_EDGE, 65535, 65535, -1000);
    for (int i = 0; i < 12; i++) send_word(OP_EDGE, 101 + i, 100 + i, -100 + 10 * i);
    send_word(OP_EDGE, 100, 112, 0);
    send_word(OP_EDGE, 112, 100, 0);
    send_word(OP_EDGE, 2, 3, WEIGHT_MAX);
    send_word(OP_CLEAR, 65535, 65535, WEIGHT_MAX);

    // component count driven to zero by growing the node count without a clear
    wait_drained();
    set_config(1, 2);
    send_word(OP_CLEAR, 0, 0, 0);
    send_word(OP_EDGE, 0, 0, 1);
    send_word(OP_EDGE, 5, 0, 2);
    wait_drained();
    set_config(1024, 2);
    send_word(OP_EDGE, 1, 0, 3);
    send_word(OP_EDGE, 2, 0, 4);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_config(PHASE_NODES[p], PHASE_K[p]);
      if (p != KEEP_PHASE) send_word(OP_CLEAR, $urandom, $urandom, int'($urandom));
      n_eff = PHASE_NODES[p];
      if (n_eff < 1) n_eff = 1;
      if (n_eff > MAX_NODES) n_eff = MAX_NODES;
      window    = (n_eff < 32) ? n_eff : 32;
      chain_tip = 0;
      w         = int'($urandom);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        roll = $urandom_range(99);
        if (roll < 1) begin
          send_word(OP_CLEAR, $urandom, $urandom, int'($urandom));
        end else if (roll < 7) begin
          send_word(OP_EDGE, $urandom, $urandom, int'($urandom));
        end else if (roll < 10) begin
          a = n_eff + $urandom_range(65535 - n_eff);
          b = $urandom_range(n_eff - 1);
          if ($urandom_range(1)) send_word(OP_EDGE, a, b, w);
          else send_word(OP_EDGE, b, a, w);
        end else begin
          if (roll < 25) begin
            a = $urandom_range(n_eff - 1);
            b = chain_tip;
            chain_tip = a;
          end else if (roll < 60) begin
            a = $urandom_range(window - 1);
            b = $urandom_range(window - 1);
          end else begin
            a = $urandom_range(n_eff - 1);
            b = $urandom_range(n_eff - 1);
          end
          if ($urandom_range(3) != 0) w = w + $urandom_range(1, 5000);
          if (w > WEIGHT_MAX) w = WEIGHT_MAX;
          send_word(OP_EDGE, a, b, w);
        end
      end
    end

    wait_drained();
    repeat (64) @(negedge clk);
    if (check_failures == 0 && words_pending == 0) begin
      $display("tb_union_find_cluster_spacing_top: PASS");
    end else begin
      $display("tb_union_find_cluster_spacing_top: FAIL");
    end
    $finish;
  end

endmodule
